FILE: rtl/stable_sorted_priority_queue_macros.svh
// Assertion macros used by the priority queue top level.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define SSPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define SSPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sspq_pkg.sv
// Shared types and constants of the sorted priority queue.
package sspq_pkg;

  localparam int CAPACITY      = 128;
  localparam int PRIORITY_BITS = 8;
  localparam int TAG_BITS      = 16;
  localparam int COUNT_BITS    = $clog2(CAPACITY + 1);
  localparam int OCC_BITS      = 8;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } sspq_status_e;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] level;
    logic [TAG_BITS-1:0]      tag;
  } sspq_entry_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic        ins;
    logic        rem;
    sspq_entry_t entry;
  } sspq_op_t;

endpackage

FILE: rtl/sspq_cell.sv
// One storage cell of the sorted chain: holds an entry and trades with its neighbors.
module sspq_cell
  import sspq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sspq_op_t    op_i,
  input  logic        left_valid_i,
  input  logic        left_gt_i,
  input  sspq_entry_t left_entry_i,
  input  logic        right_valid_i,
  input  sspq_entry_t right_entry_i,
  output logic        valid_o,
  output logic        gt_o,
  output sspq_entry_t entry_o
);

  logic        valid_q, valid_d;
  sspq_entry_t entry_q, entry_d;

  // The new entry goes ahead of this cell's entry only when strictly more urgent.
  assign gt_o    = valid_q && (op_i.entry.level < entry_q.level);
  assign valid_o = valid_q;
  assign entry_o = entry_q;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (op_i.ins) begin
      if (gt_o || !valid_q) begin
        // Take the left neighbor's entry if it moves down, else the new one.
        entry_d = left_gt_i ? left_entry_i : op_i.entry;
        valid_d = valid_q | left_valid_i;
      end
    end else if (op_i.rem) begin
      valid_d = right_valid_i;
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

FILE: rtl/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue built from a chain of cells.
//
// Usage: each input item is either an insert (mode 0) carrying a priority
// level and a tag, or a remove (mode 1). Lower levels are more urgent, and
// entries of equal level leave in the order they arrived. Every item gives
// exactly one result item with a status, the removed level and tag (zero
// when nothing is removed) and the occupancy after the item.
// Both channels use valid and stall; an item moves at a clock edge with
// valid high and stall low.
// The result is offered in the cycle after acceptance. The block takes one
// item per cycle unless the receiver stalls a full result register. All
// cells compare the new level against their own entry and shift by one place
// in the same cycle, so the queue depth does not affect throughput.
// Reset empties the queue at once by clearing each cell's valid bit; the
// stored entries themselves are not cleared.
// When the receiver stalls, the result register holds its item and the input
// side stalls in the same cycle, so no item is lost or duplicated.
// An insert into a full queue reports a full status and leaves it unchanged;
// a remove from an empty queue reports an empty status.
`include "stable_sorted_priority_queue_macros.svh"

module stable_sorted_priority_queue
  import sspq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     mode_i,
  input  logic [PRIORITY_BITS-1:0] task_priority_i,
  input  logic [TAG_BITS-1:0]      task_tag_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic [PRIORITY_BITS-1:0] out_priority_o,
  output logic [TAG_BITS-1:0]      out_tag_o,
  output logic [OCC_BITS-1:0]      occupancy_o
);

  logic                     in_accept;
  logic                     full, empty;
  sspq_op_t                 op;

  logic [CAPACITY-1:0]      cell_valid;
  logic [CAPACITY-1:0]      cell_gt;
  sspq_entry_t              cell_entry [CAPACITY];

  logic [COUNT_BITS-1:0]    count_q, count_d;

  logic                     out_valid_q, out_valid_d;
  sspq_status_e             status_q, status_d;
  logic [PRIORITY_BITS-1:0] prio_q, prio_d;
  logic [TAG_BITS-1:0]      tag_q, tag_d;
  logic [OCC_BITS-1:0]      occ_q, occ_d;

  // The result register is the only buffer, so the input stalls while it is
  // full and the receiver is stalling.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Cells fill from the head, so the end cells tell whether the queue is full or empty.
  assign full  = cell_valid[CAPACITY-1];
  assign empty = !cell_valid[0];

  always_comb begin
    op.ins         = in_accept && (mode_i == MODE_INSERT) && !full;
    op.rem         = in_accept && (mode_i == MODE_REMOVE) && !empty;
    op.entry.level = task_priority_i;
    op.entry.tag   = task_tag_i;
  end

  // The chain: cell 0 is the head. Insertion data moves toward the tail,
  // removal data moves toward the head.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic        left_valid;
    logic        left_gt;
    sspq_entry_t left_entry;
    logic        right_valid;
    sspq_entry_t right_entry;

    if (k == 0) begin : g_head
      // The head sees an always-occupied, never-displaced left neighbor.
      assign left_valid = 1'b1;
      assign left_gt    = 1'b0;
      assign left_entry = '0;
    end else begin : g_body
      assign left_valid = cell_valid[k-1];
      assign left_gt    = cell_gt[k-1];
      assign left_entry = cell_entry[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_entry = '0;
    end else begin : g_inner
      assign right_valid = cell_valid[k+1];
      assign right_entry = cell_entry[k+1];
    end

    sspq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (op),
      .left_valid_i  (left_valid),
      .left_gt_i     (left_gt),
      .left_entry_i  (left_entry),
      .right_valid_i (right_valid),
      .right_entry_i (right_entry),
      .valid_o       (cell_valid[k]),
      .gt_o          (cell_gt[k]),
      .entry_o       (cell_entry[k])
    );
  end

  // Entry count and the result item for the accepted operation.
  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    prio_d      = prio_q;
    tag_d       = tag_q;
    occ_d       = occ_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
      prio_d      = '0;
      tag_d       = '0;
      if (mode_i == MODE_INSERT) begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_INSERTED;
          count_d  = count_q + COUNT_BITS'(1);
        end
      end else begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          status_d = ST_REMOVED;
          prio_d   = cell_entry[0].level;
          tag_d    = cell_entry[0].tag;
          count_d  = count_q - COUNT_BITS'(1);
        end
      end
      occ_d = OCC_BITS'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    prio_q   <= prio_d;
    tag_q    <= tag_d;
    occ_q    <= occ_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_priority_o = prio_q;
  assign out_tag_o      = tag_q;
  assign occupancy_o    = occ_q;

  // The entry count must agree with whether the head cell is occupied.
  `SSPQ_ASSERT(a_count_head, (count_q == '0) == !cell_valid[0], "count disagrees with head cell")
  // Occupied cells form one unbroken run starting at the head.
  `SSPQ_ASSERT(a_valid_run, ((cell_valid + CAPACITY'(1)) & cell_valid) == '0, "gap in cell chain")
  // The two head entries stay in priority order.
  `SSPQ_ASSERT(a_head_order, !cell_valid[1] || (cell_entry[0].level <= cell_entry[1].level),
               "head entries out of order")
  // An insert accepted while full reports a full status.
  `SSPQ_ASSERT_NEXT(a_full_status, in_accept && (mode_i == MODE_INSERT) && full,
                    status_q == ST_FULL, "insert into full queue not rejected")

endmodule
